// ===== rtl/dls_pkg.sv =====
// Shared types and constants for the decimal list statistics unit.
package dls_pkg;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int unsigned ERR_BAD = 0;
	localparam int unsigned ERR_OVF = 1;

	// sequencer states, one-hot
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_MUL   = 8'b0000_0010,
		S_ADD   = 8'b0000_0100,
		S_CLOSE = 8'b0000_1000,
		S_ABS   = 8'b0001_0000,
		S_DIV   = 8'b0010_0000,
		S_SIGN  = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} dls_state_t;

	// control of the shared adder
	typedef struct packed {
		logic sub;
		logic neg_b;
	} dls_alu_ctl_t;

endpackage

// ===== rtl/dls_alu.sv =====
// Shared add/subtract unit used by the arithmetic steps of the sequencer.
module dls_alu
	import dls_pkg::*;
#(
	parameter int W = 34
) (
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	input  dls_alu_ctl_t        ctl,
	output logic signed [W-1:0] res
);

	logic signed [W-1:0] b_eff;

	// neg_b and sub both subtract b; neg_b is used when a is zero (negate)
	assign b_eff = (ctl.sub || ctl.neg_b) ? ~b : b;
	assign res   = a + b_eff + W'(ctl.sub || ctl.neg_b);

endmodule

// ===== rtl/decimal_list_statistics_unit.sv =====
// Top level: statistics over a streamed comma-separated list of signed decimals.
//
// One ASCII byte enters per request on the slave stream; a request with tlast
// closes the list and one result then appears on the master stream: minimum,
// maximum, count and the mean in Q8 (sum*256/count, truncated toward zero,
// saturated). A '-' anywhere in a field makes it negative, empty fields are
// skipped, other bytes raise bad_char. Field magnitude, sum and count
// saturate and raise overflow. An empty list reports empty_res with zero
// min, max and mean. All work runs through one shared adder under a small
// sequencer, and the input is not ready while a byte is in work: '-' or a
// bad byte is taken in idle, a comma goes through the close step, a digit
// through the multiply and add steps (times ten and add use the adder twice).
// A final byte other than a comma then also closes the field, then come the
// absolute sum, restoring division (one quotient bit per cycle through the
// adder), the sign and the output register load (skipped straight to load for
// an empty list). The result register lets the next list start while the
// previous result still waits; a new final byte waits only if it is not taken.
module decimal_list_statistics_unit
	import dls_pkg::*;
#(
	parameter int VALUE_BITS = 16,
	parameter int MAX_FIELDS = 255
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_char
	input  logic        s_axis_tlast,  // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // [15:0] minimum, [31:16] maximum,
	                                   // [55:32] average_q8, [63:56] value_count
	output logic [2:0]  m_axis_tuser   // [0] empty_res, [1] bad_char, [2] overflow
);

	localparam int MAG_W  = VALUE_BITS - 1;
	localparam int SUM_W  = VALUE_BITS + 9;
	localparam int AVG_W  = VALUE_BITS + 8;
	localparam int DVD_W  = SUM_W + 8;
	localparam int ALU_W  = VALUE_BITS + 18;
	localparam int CNT_W  = $clog2(MAX_FIELDS + 1);
	localparam int DCNT_W = $clog2(DVD_W + 1);

	localparam logic signed [ALU_W-1:0] MAG_MAX_A =
		ALU_W'((64'd1 << (VALUE_BITS - 1)) - 64'd1);
	localparam logic signed [ALU_W-1:0] SUM_MAX_A =
		ALU_W'((64'd1 << (SUM_W - 1)) - 64'd1);
	localparam logic signed [ALU_W-1:0] SUM_MIN_A = -SUM_MAX_A - ALU_W'(1);
	localparam logic signed [ALU_W-1:0] AVG_MAX_A =
		ALU_W'((64'd1 << (AVG_W - 1)) - 64'd1);
	localparam logic signed [ALU_W-1:0] AVG_MIN_A = -AVG_MAX_A - ALU_W'(1);
	localparam logic signed [VALUE_BITS-1:0] VAL_MAX = VALUE_BITS'(MAG_MAX_A);
	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = -VAL_MAX - VALUE_BITS'(1);
	localparam logic [CNT_W-1:0]  MAXF_C = CNT_W'(MAX_FIELDS);
	localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DVD_W);

	dls_state_t state_q;

	// list accumulators
	logic [MAG_W-1:0]             mag_q;
	logic                         neg_q;
	logic                         in_field_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic [CNT_W-1:0]             total_q;
	logic signed [VALUE_BITS-1:0] min_q;
	logic signed [VALUE_BITS-1:0] max_q;
	logic [1:0]                   err_q;

	// work registers
	logic [7:0]              char_q;
	logic                    last_q;
	logic signed [ALU_W-1:0] tmp_q;
	logic [DVD_W-1:0]        dvd_q;
	logic [CNT_W-1:0]        rem_q;
	logic [DCNT_W-1:0]       div_cnt_q;
	logic signed [AVG_W-1:0] avg_q;

	// output register
	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic [2:0]  out_user_q;

	logic signed [ALU_W-1:0] alu_a;
	logic signed [ALU_W-1:0] alu_b;
	logic signed [ALU_W-1:0] alu_res;
	dls_alu_ctl_t            alu_ctl;

	logic                         in_req;
	logic                         is_digit;
	logic signed [VALUE_BITS-1:0] fld_val;
	logic [CNT_W:0]               rem_shift;
	logic                         out_free;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_req        = s_axis_tvalid && s_axis_tready;
	assign is_digit      = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign fld_val       = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
	assign rem_shift     = {rem_q, dvd_q[DVD_W-1]};

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// operand selection for the shared adder
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_ctl = '0;
		unique case (state_q)
			S_MUL: begin
				alu_a = ALU_W'(mag_q) <<< 3;
				alu_b = ALU_W'(mag_q) <<< 1;
			end
			S_ADD: begin
				alu_a = tmp_q;
				alu_b = ALU_W'(char_q - CH_ZERO);
			end
			S_CLOSE: begin
				alu_a       = ALU_W'(sum_q);
				alu_b       = ALU_W'(mag_q);
				alu_ctl.sub = neg_q;
			end
			S_ABS: begin
				alu_b         = ALU_W'(sum_q);
				alu_ctl.neg_b = sum_q[SUM_W-1];
			end
			S_DIV: begin
				alu_a       = ALU_W'(rem_shift);
				alu_b       = ALU_W'(total_q);
				alu_ctl.sub = 1'b1;
			end
			S_SIGN: begin
				alu_b         = ALU_W'(dvd_q);
				alu_ctl.neg_b = sum_q[SUM_W-1];
			end
			S_IDLE, S_EMIT: begin
				alu_a = '0;
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	dls_alu #(
		.W(ALU_W)
	) u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.ctl(alu_ctl),
		.res(alu_res)
	);

	// work registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_req) begin
			char_q <= s_axis_tdata;
		end
		if (state_q == S_MUL) begin
			tmp_q <= alu_res;
		end
		if (state_q == S_ABS) begin
			dvd_q <= DVD_W'({alu_res[SUM_W-1:0], 8'h00});
			rem_q <= '0;
		end
		if (state_q == S_DIV) begin
			if (!alu_res[ALU_W-1]) begin
				rem_q <= alu_res[CNT_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[CNT_W-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			end
		end
		if (state_q == S_SIGN) begin
			priority if (alu_res > AVG_MAX_A) begin
				avg_q <= AVG_W'(AVG_MAX_A);
			end else if (alu_res < AVG_MIN_A) begin
				avg_q <= AVG_W'(AVG_MIN_A);
			end else begin
				avg_q <= AVG_W'(alu_res);
			end
		end
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			in_field_q  <= 1'b0;
			sum_q       <= '0;
			total_q     <= '0;
			min_q       <= VAL_MAX;
			max_q       <= VAL_MIN;
			err_q       <= '0;
			last_q      <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= '0;
		end else begin
			// a load wins over a hand-off in the same cycle
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_req) begin
						last_q <= s_axis_tlast;
						priority if (s_axis_tdata == CH_COMMA) begin
							state_q <= S_CLOSE;
						end else if (s_axis_tdata == CH_MINUS) begin
							in_field_q <= 1'b1;
							neg_q      <= 1'b1;
							if (s_axis_tlast) begin
								state_q <= S_CLOSE;
							end
						end else if (is_digit) begin
							in_field_q <= 1'b1;
							state_q    <= S_MUL;
						end else begin
							err_q[ERR_BAD] <= 1'b1;
							if (s_axis_tlast) begin
								state_q <= S_CLOSE;
							end
						end
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (alu_res > MAG_MAX_A) begin
						mag_q          <= MAG_MAX_A[MAG_W-1:0];
						err_q[ERR_OVF] <= 1'b1;
					end else begin
						mag_q <= alu_res[MAG_W-1:0];
					end
					state_q <= last_q ? S_CLOSE : S_IDLE;
				end
				S_CLOSE: begin
					if (in_field_q) begin
						if (total_q >= MAXF_C) begin
							err_q[ERR_OVF] <= 1'b1;
						end else begin
							total_q <= total_q + CNT_W'(1);
							priority if (alu_res > SUM_MAX_A) begin
								sum_q          <= SUM_W'(SUM_MAX_A);
								err_q[ERR_OVF] <= 1'b1;
							end else if (alu_res < SUM_MIN_A) begin
								sum_q          <= SUM_W'(SUM_MIN_A);
								err_q[ERR_OVF] <= 1'b1;
							end else begin
								sum_q <= SUM_W'(alu_res);
							end
							if (fld_val < min_q) begin
								min_q <= fld_val;
							end
							if (fld_val > max_q) begin
								max_q <= fld_val;
							end
						end
					end
					mag_q      <= '0;
					neg_q      <= 1'b0;
					in_field_q <= 1'b0;
					priority if (!last_q) begin
						state_q <= S_IDLE;
					end else if (in_field_q && (total_q < MAXF_C)) begin
						state_q <= S_ABS;
					end else if (total_q == '0) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_ABS;
					end
				end
				S_ABS: begin
					div_cnt_q <= DIV_STEPS;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q - DCNT_W'(1);
					if (div_cnt_q == DCNT_W'(1)) begin
						state_q <= S_SIGN;
					end
				end
				S_SIGN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (total_q == '0) begin
							out_data_q <= '0;
						end else begin
							out_data_q <= {8'(total_q), 24'(avg_q), 16'(max_q), 16'(min_q)};
						end
						out_user_q <= {err_q[ERR_OVF], err_q[ERR_BAD], (total_q == '0)};
						sum_q      <= '0;
						total_q    <= '0;
						min_q      <= VAL_MAX;
						max_q      <= VAL_MIN;
						err_q      <= '0;
						last_q     <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/dls_checker.sv =====
// Port-level checks for the decimal list statistics unit, with its bind.
module dls_checker #(
	parameter int VALUE_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// an empty list reports all-zero statistics
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
		else $error("empty list with nonzero statistics");

	// a non-empty list has min not above max
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] && (VALUE_BITS <= 16) |->
			$signed(m_axis_tdata[15:0]) <= $signed(m_axis_tdata[31:16]))
		else $error("minimum above maximum");

	// the final byte always starts work that takes the input out of ready
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input ready right after final byte");

endmodule

bind decimal_list_statistics_unit dls_checker #(
	.VALUE_BITS(VALUE_BITS)
) u_dls_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the decimal list statistics unit.
module tb;
	import dls_pkg::*;

	localparam int VALUE_BITS = 16;
	localparam int MAX_FIELDS = 255;
	localparam longint MAG_MAX = (64'sd1 <<< (VALUE_BITS - 1)) - 1;
	localparam longint SUM_MAX = (64'sd1 <<< (VALUE_BITS + 8)) - 1;
	localparam longint AVG_MAX = (64'sd1 <<< (VALUE_BITS + 7)) - 1;
	localparam int TAIL_CYCLES = 4 * (VALUE_BITS + 24);

	// one byte request on the input stream
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_req_t;

	// one list summary as it leaves the block
	typedef struct packed {
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic signed [23:0] mean_q8;
		logic [7:0]         cnt;
		logic               empty;
		logic               bad;
		logic               ovf;
	} list_stats_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] in_char
	logic        s_axis_tlast = 1'b0; // last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;        // [15:0] min, [31:16] max, [55:32] avg_q8, [63:56] count
	logic [2:0]  m_axis_tuser;        // [0] empty_res, [1] bad_char, [2] overflow

	char_req_t   req_q[$];
	list_stats_t stats_exp_q[$];
	char_req_t   next_req;
	int          err_cnt = 0;
	int          queued = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_reqs = 0;
	int          holds_served = 0;
	int          hold_left = 0;

	// predictor state
	logic [14:0]        fld_mag;
	logic               fld_neg;
	logic               fld_open;
	logic signed [24:0] sum_acc;
	int                 n_fields;
	logic signed [15:0] lo_val;
	logic signed [15:0] hi_val;
	logic               saw_bad;
	logic               saw_ovf;

	decimal_list_statistics_unit #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_FIELDS(MAX_FIELDS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_list();
		fld_mag  = '0;
		fld_neg  = 1'b0;
		fld_open = 1'b0;
		sum_acc  = '0;
		n_fields = 0;
		lo_val   = 16'sh7FFF;
		hi_val   = 16'sh8000;
		saw_bad  = 1'b0;
		saw_ovf  = 1'b0;
	endfunction

	// fold the open field into the running totals; full count drops it
	function automatic void close_field();
		int     v;
		longint s;
		if (!fld_open)
			return;
		v = fld_neg ? -int'(fld_mag) : int'(fld_mag);
		if (n_fields >= MAX_FIELDS) begin
			saw_ovf = 1'b1;
		end else begin
			n_fields++;
			s = longint'(sum_acc) + v;
			if (s > SUM_MAX) begin
				s = SUM_MAX;
				saw_ovf = 1'b1;
			end else if (s < -SUM_MAX - 1) begin
				s = -SUM_MAX - 1;
				saw_ovf = 1'b1;
			end
			sum_acc = s[24:0];
			if (v < lo_val)
				lo_val = v[15:0];
			if (v > hi_val)
				hi_val = v[15:0];
		end
		fld_mag  = '0;
		fld_neg  = 1'b0;
		fld_open = 1'b0;
	endfunction

	// advance the predictor by one accepted byte; a final byte yields a summary
	function automatic void predict_stats(logic [7:0] ch, logic last);
		int          m;
		longint      avg;
		list_stats_t r;
		if (ch == CH_COMMA) begin
			close_field();
		end else if (ch == CH_MINUS) begin
			fld_open = 1'b1;
			fld_neg  = 1'b1;
		end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			fld_open = 1'b1;
			m = int'(fld_mag) * 10 + int'(ch - CH_ZERO);
			if (m > MAG_MAX) begin
				m = int'(MAG_MAX);
				saw_ovf = 1'b1;
			end
			fld_mag = m[14:0];
		end else begin
			saw_bad = 1'b1;
		end
		if (!last)
			return;
		close_field();
		r = '0;
		r.empty = (n_fields == 0);
		if (!r.empty) begin
			// SV division of signed operands truncates toward zero
			avg = (longint'(sum_acc) * 256) / longint'(n_fields);
			if (avg > AVG_MAX)
				avg = AVG_MAX;
			else if (avg < -AVG_MAX - 1)
				avg = -AVG_MAX - 1;
			r.lo      = lo_val;
			r.hi      = hi_val;
			r.mean_q8 = avg[23:0];
		end
		r.cnt = n_fields[7:0];
		r.bad = saw_bad;
		r.ovf = saw_ovf;
		stats_exp_q.push_back(r);
		clear_list();
	endfunction

	initial clear_list();

	// sender: hold a request until taken, then maybe idle before the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_stats(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = req_q.pop_front();
					s_axis_tdata  <= next_req.ch;
					s_axis_tlast  <= next_req.last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic cmp_field(string name, logic signed [63:0] want,
	                         logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			err_cnt++;
		end
	endtask

	// receiver: random stalls, plus a long hold-off whenever one is requested
	always @(posedge clk or negedge arst_n) begin
		list_stats_t want;
		list_stats_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left     <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{lo: m_axis_tdata[15:0], hi: m_axis_tdata[31:16],
				        mean_q8: m_axis_tdata[55:32], cnt: m_axis_tdata[63:56],
				        empty: m_axis_tuser[0], bad: m_axis_tuser[1], ovf: m_axis_tuser[2]};
				if (stats_exp_q.size() == 0) begin
					$display("%0t: unexpected summary, expected none actual %h_%h",
					         $time, m_axis_tdata, m_axis_tuser);
					err_cnt++;
				end else begin
					want = stats_exp_q.pop_front();
					cmp_field("minimum", want.lo, got.lo);
					cmp_field("maximum", want.hi, got.hi);
					cmp_field("average_q8", want.mean_q8, got.mean_q8);
					cmp_field("value_count", want.cnt, got.cnt);
					cmp_field("empty_res", want.empty, got.empty);
					cmp_field("bad_char", want.bad, got.bad);
					cmp_field("overflow", want.ovf, got.ovf);
				end
			end
			if (holds_served != hold_reqs) begin
				holds_served  <= hold_reqs;
				hold_left     <= 400;
				m_axis_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left     <= hold_left - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic queue_list(input logic [7:0] body[$]);
		foreach (body[i])
			req_q.push_back('{ch: body[i], last: (i == body.size() - 1)});
		queued += body.size();
	endtask

	task automatic queue_text(string s);
		logic [7:0] body[$];
		for (int i = 0; i < s.len(); i++)
			body.push_back(s[i]);
		queue_list(body);
	endtask

	function automatic logic [7:0] bad_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == CH_COMMA || b == CH_MINUS || (b >= CH_ZERO && b <= CH_NINE));
		return b;
	endfunction

	// mostly well-formed lists with random content, some noise and odd fragments
	task automatic queue_random_list(int max_fields);
		logic [7:0] body[$];
		int         kind;
		int         nf;
		int         nd;
		kind = $urandom_range(0, 99);
		if (kind < 80) begin
			nf = $urandom_range(1, max_fields);
			for (int f = 0; f < nf; f++) begin
				if (f > 0)
					body.push_back(CH_COMMA);
				if ($urandom_range(0, 9) == 0)
					continue;
				if ($urandom_range(0, 2) == 0)
					body.push_back(CH_MINUS);
				// a few long fields push the magnitude into saturation
				nd = ($urandom_range(0, 6) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
				for (int d = 0; d < nd; d++) begin
					body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
					if ($urandom_range(0, 29) == 0)
						body.push_back(bad_byte());
					if ($urandom_range(0, 39) == 0)
						body.push_back(CH_MINUS);
				end
			end
			if ($urandom_range(0, 4) == 0)
				body.push_back(CH_COMMA);
		end else if (kind < 92) begin
			nd = $urandom_range(1, 10);
			repeat (nd)
				body.push_back(($urandom_range(0, 3) == 0) ? CH_COMMA : 8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 3))
				0: body.push_back(CH_COMMA);
				1: body.push_back(CH_MINUS);
				2: body.push_back(bad_byte());
				default: body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			endcase
		end
		queue_list(body);
	endtask

	// sender stays quiet until every summary has come back
	task automatic drain();
		while (req_q.size() != 0 || s_axis_tvalid || stats_exp_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int send_pct, int recv_pct, int n_items, int max_fields);
		int target;
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		target = queued + n_items;
		while (queued < target)
			queue_random_list(max_fields);
		drain();
	endtask

	initial begin : stimulus
		logic [7:0] body[$];
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty list, bad byte only, sign only, saturated magnitude,
		// minus inside a field with empty fields, bad byte with trailing comma, zero
		queue_text(",");
		body.push_back(8'hFF);
		queue_list(body);
		queue_text("-");
		queue_text("99999");
		queue_text("1,-2,,3-");
		queue_text(",5x,");
		queue_text("0");
		drain();

		// long receiver hold-off while short lists keep coming: input must stall
		@(negedge clk);
		hold_reqs++;
		run_phase(0, 0, 60, 2);

		// more fields than the count can hold
		body.delete();
		for (int f = 0; f < MAX_FIELDS + 4; f++) begin
			if (f > 0)
				body.push_back(CH_COMMA);
			if ($urandom_range(0, 4) == 0)
				body.push_back(CH_MINUS);
			body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		end
		queue_list(body);
		drain();

		run_phase(0, 0, 90, 5);
		run_phase(49, 0, 90, 5);
		run_phase(0, 49, 90, 5);
		run_phase(38, 38, 90, 5);
		run_phase(0, 0, 90, 8);

		recv_stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && stats_exp_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// ===== decimal_list_statistics_unit.f =====
rtl/dls_pkg.sv
rtl/dls_alu.sv
rtl/decimal_list_statistics_unit.sv
rtl/dls_checker.sv
tb/tb.sv
